FILE: sv/fir_pkg.sv
`default_nettype none

package fir_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_FILTER = 2'd0;
  localparam logic [1:0] REQ_LOAD   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Fixed-point formats
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 40;
  localparam int FRAC_W   = 15;
  localparam int TAP_W    = 8;
  localparam int IDX_W    = 7;

  localparam logic [TAP_W-1:0] TAP_COUNT_RESET = 8'd101;

  // Microprogram step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_LOAD  = 3'd1;
  localparam step_t STEP_CLEAR = 3'd2;
  localparam step_t STEP_PUSH  = 3'd3;
  localparam step_t STEP_LOOP  = 3'd4;
  localparam step_t STEP_FINAL = 3'd5;

  // Sequencer operations
  typedef enum logic [2:0] {
    SEQ_NEXT     = 3'd0,  // advance to the following step
    SEQ_JUMP     = 3'd1,  // go to target
    SEQ_DISPATCH = 3'd2,  // hold until a beat, then branch on req_type
    SEQ_LOOP     = 3'd3,  // hold while the MAC pipeline is busy, then advance
    SEQ_WAIT_OUT = 3'd4   // hold until the output register is free, then jump
  } seq_op_t;

  // Datapath controls, one bit per action
  typedef struct packed {
    logic in_ready;
    logic wr_coef;
    logic clr_hist;
    logic push;
    logic run;
    logic emit;
  } ctl_t;

  // Status returned to the sequencer
  typedef struct packed {
    logic       accept;
    logic [1:0] req_type;
    logic       busy;
    logic       out_free;
  } stat_t;

  typedef struct packed {
    ctl_t    ctl;
    seq_op_t seq;
    step_t   target;
  } uword_t;

  // Control store
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    w        = '0;
    w.seq    = SEQ_JUMP;
    w.target = STEP_IDLE;
    case (step)
      STEP_IDLE: begin
        w.ctl.in_ready = 1'b1;
        w.seq          = SEQ_DISPATCH;
      end
      STEP_LOAD: begin
        w.ctl.wr_coef = 1'b1;
      end
      STEP_CLEAR: begin
        w.ctl.clr_hist = 1'b1;
      end
      STEP_PUSH: begin
        w.ctl.push = 1'b1;
        w.seq      = SEQ_NEXT;
      end
      STEP_LOOP: begin
        w.ctl.run = 1'b1;
        w.seq     = SEQ_LOOP;
      end
      STEP_FINAL: begin
        w.ctl.emit = 1'b1;
        w.seq      = SEQ_WAIT_OUT;
      end
      default: begin
        w.seq = SEQ_JUMP;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fir_in_if.sv
`default_nettype none

interface fir_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] sample;
  logic [6:0]         coef_index;
  logic signed [15:0] coef_value;

  modport source (output valid, output req_type, output sample, output coef_index,
                  output coef_value, input ready);
  modport sink (input valid, input req_type, input sample, input coef_index,
                input coef_value, output ready);
endinterface

`default_nettype wire

FILE: sv/fir_out_if.sv
`default_nettype none

interface fir_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] filtered;
  logic               saturated;

  modport source (output valid, output filtered, output saturated, input ready);
  modport sink (input valid, input filtered, input saturated, output ready);
endinterface

`default_nettype wire

FILE: sv/fir_filter_top.sv
`default_nettype none
// Direct-form FIR filter, 16-bit samples, Q1.15 coefficients, 40-bit accumulator.
// in_ch takes request beats: filter a sample, load a coefficient, or clear the
// sample history. out_ch gives one beat per filter request: the sum shifted
// right 15 (floor) and saturated to 16 bits, with a saturation flag.
// cfg_wr_en / cfg_wr_data write tap_count; write it only while the block is idle.
// A microcoded sequencer drives one shared multiply-accumulate pipeline that
// visits one tap per cycle over T = min(tap_count, MAX_TAPS) taps. A filter beat
// runs the push, loop and final steps; its result is registered once the output
// register is free, and the next beat is taken in the cycle after. Load and clear
// beats run their own step. Throughput is set by that single MAC walking the taps.
// Reset restores tap_count to 101 and empties the history through a fill count,
// so no clearing pass is needed; coefficients are undefined until loaded.
// A finished result waits in the output register while the next request is
// taken; a stalled receiver only holds the block at the end of the next filter
// beat.
module fir_filter_top #(
  parameter int MAX_TAPS = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [fir_pkg::TAP_W-1:0] cfg_wr_data,
  fir_in_if.sink                         in_ch,
  fir_out_if.source                      out_ch
);

  fir_pkg::ctl_t  ctl;
  fir_pkg::stat_t stat;

  assign in_ch.ready = ctl.in_ready;

  fir_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  fir_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_ch.valid),
    .req_type    (in_ch.req_type),
    .sample      (in_ch.sample),
    .coef_index  (in_ch.coef_index),
    .coef_value  (in_ch.coef_value),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .filtered    (out_ch.filtered),
    .saturated   (out_ch.saturated)
  );

endmodule

`default_nettype wire

FILE: sv/fir_ram.sv
`default_nettype none

module fir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/fir_seq.sv
`default_nettype none

module fir_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire fir_pkg::stat_t stat,
  output fir_pkg::ctl_t       ctl
);

  fir_pkg::step_t  upc;
  fir_pkg::step_t  upc_next;
  fir_pkg::uword_t uword;

  // Fetch the control word of the current step
  assign uword = fir_pkg::ucode(upc);
  assign ctl   = uword.ctl;

  // Pick the next step
  always_comb begin
    upc_next = upc;
    case (uword.seq)
      fir_pkg::SEQ_NEXT: begin
        upc_next = fir_pkg::step_t'(upc + 3'd1);
      end
      fir_pkg::SEQ_JUMP: begin
        upc_next = uword.target;
      end
      fir_pkg::SEQ_DISPATCH: begin
        if (stat.accept) begin
          unique case (stat.req_type)
            fir_pkg::REQ_FILTER: upc_next = fir_pkg::STEP_PUSH;
            fir_pkg::REQ_LOAD:   upc_next = fir_pkg::STEP_LOAD;
            fir_pkg::REQ_CLEAR:  upc_next = fir_pkg::STEP_CLEAR;
            default:             upc_next = fir_pkg::STEP_IDLE;
          endcase
        end
      end
      fir_pkg::SEQ_LOOP: begin
        if (!stat.busy) begin
          upc_next = fir_pkg::step_t'(upc + 3'd1);
        end
      end
      fir_pkg::SEQ_WAIT_OUT: begin
        if (stat.out_free) begin
          upc_next = uword.target;
        end
      end
      default: begin
        upc_next = fir_pkg::STEP_IDLE;
      end
    endcase
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= fir_pkg::STEP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/fir_dp.sv
`default_nettype none

module fir_dp #(
  parameter int MAX_TAPS = 128
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire fir_pkg::ctl_t                       ctl,
  output fir_pkg::stat_t                           stat,
  input  wire logic                                cfg_wr_en,
  input  wire logic [fir_pkg::TAP_W-1:0]           cfg_wr_data,
  input  wire logic                                in_valid,
  input  wire logic [1:0]                          req_type,
  input  wire logic signed [fir_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [fir_pkg::IDX_W-1:0]           coef_index,
  input  wire logic signed [fir_pkg::SAMPLE_W-1:0] coef_value,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic signed [fir_pkg::SAMPLE_W-1:0]      filtered,
  output logic                                     saturated
);

  localparam int AW   = $clog2(MAX_TAPS);
  localparam int CW   = $clog2(MAX_TAPS + 1);
  localparam int CMPW = (CW > fir_pkg::TAP_W) ? CW : fir_pkg::TAP_W;
  localparam int QW   = fir_pkg::ACC_W - fir_pkg::FRAC_W;
  localparam int SW   = fir_pkg::SAMPLE_W;

  localparam logic [AW-1:0] PTR_LAST = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_TAPS);

  logic                      accept;
  logic [fir_pkg::TAP_W-1:0] tap_count;
  logic [fir_pkg::IDX_W-1:0] coef_index_r;
  logic [SW-1:0]             coef_value_r;
  logic [SW-1:0]             sample_r;
  logic [AW-1:0]             ptr;
  logic [CW-1:0]             fill;
  logic [CW-1:0]             taps;
  logic [CW-1:0]             taps_next;
  logic [CW-1:0]             j;
  logic [AW-1:0]             pos;
  logic                      issue;
  logic                      v1;
  logic                      z1;
  logic                      v2;
  logic signed [fir_pkg::PROD_W-1:0] prod;
  logic [fir_pkg::ACC_W-1:0] acc;
  logic [SW-1:0]             coef_rd;
  logic [SW-1:0]             hist_rd;
  logic [SW-1:0]             hist_sel;
  logic                      coef_ok;
  logic                      out_free;
  logic [QW-1:0]             q;
  logic                      q_sat;
  logic [SW-1:0]             q_clip;

  assign accept   = in_valid && ctl.in_ready;
  assign issue    = ctl.run && (j < taps);
  assign out_free = !out_valid || out_ready;

  assign stat.accept   = accept;
  assign stat.req_type = req_type;
  assign stat.busy     = issue || v1 || v2;
  assign stat.out_free = out_free;

  // Clamp the tap count to the store depth
  assign taps_next = (CMPW'(tap_count) > CMPW'(MAX_TAPS)) ? CNT_MAX : CW'(tap_count);

  // Drop loads beyond the store
  assign coef_ok = (32'(coef_index_r) < MAX_TAPS);

  // Tap count register
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= fir_pkg::TAP_COUNT_RESET;
    end else if (cfg_wr_en) begin
      tap_count <= cfg_wr_data;
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      coef_index_r <= coef_index;
      coef_value_r <= coef_value;
      sample_r     <= sample;
    end
  end

  fir_ram #(.WIDTH(SW), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (ctl.wr_coef && coef_ok),
    .waddr (AW'(coef_index_r)),
    .wdata (coef_value_r),
    .raddr (j[AW-1:0]),
    .rdata (coef_rd)
  );

  fir_ram #(.WIDTH(SW), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (ptr),
    .wdata (sample_r),
    .raddr (pos),
    .rdata (hist_rd)
  );

  // History pointer and fill count; entries beyond the fill read as zero
  always_ff @(posedge clk) begin
    if (rst || ctl.clr_hist) begin
      ptr  <= '0;
      fill <= '0;
    end else if (ctl.push) begin
      ptr  <= (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
      fill <= (fill == CNT_MAX) ? fill : fill + 1'b1;
    end
  end

  // Issue stage: walk taps forward and history backward
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      j    <= '0;
      pos  <= ptr;
      taps <= taps_next;
    end else if (issue) begin
      j   <= j + 1'b1;
      pos <= (pos == '0) ? PTR_LAST : pos - 1'b1;
    end
    z1 <= (j >= fill);
  end

  // Multiply and accumulate stages
  assign hist_sel = z1 ? '0 : hist_rd;

  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= $signed(coef_rd) * $signed(hist_sel);
    end
    if (ctl.push) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(fir_pkg::ACC_W - fir_pkg::PROD_W){prod[fir_pkg::PROD_W-1]}}, prod};
    end
  end

  // Floor shift and saturate
  assign q      = acc[fir_pkg::ACC_W-1:fir_pkg::FRAC_W];
  assign q_sat  = !((&q[QW-1:SW-1]) || !(|q[QW-1:SW-1]));
  assign q_clip = q_sat ? (q[QW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}})
                        : q[SW-1:0];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.emit && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && out_free) begin
      filtered  <= $signed(q_clip);
      saturated <= q_sat;
    end
  end

endmodule

`default_nettype wire
